[rtl/sort_merge_semi_join_defines.svh]
// Assertion macros for the sort-merge semi-join block.
// Used by the top level only; needs clk and rst_n in scope where expanded.
`ifndef SORT_MERGE_SEMI_JOIN_DEFINES_SVH
`define SORT_MERGE_SEMI_JOIN_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SMSJ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smsj check failed");
// next-cycle implication
`define SMSJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smsj check failed");
`else
`define SMSJ_ASSERT_NOW(label, ante, cons)
`define SMSJ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/smsj_pkg.sv]
// Shared constants, state encoding and controller/datapath structs
// for the sort-merge semi-join block. No dependencies.
package smsj_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int ROW_COLUMNS = 2;
    localparam int KEY_W       = 32;
    localparam int ADDR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // accept a load beat
        logic probe;      // accept a probe beat
        logic read;       // read store at pointer
        logic step;       // advance pointer, read next entry
        logic take_hit;   // latch equality of fetched key
        logic clear_hit;  // latch a miss
        logic emit;       // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_range;   // pointer below count
        logic next_in;    // pointer + 1 below count
        logic less;       // fetched key below row key
        logic out_free;   // result register can take a beat
    } sts_t;

endpackage

[rtl/smsj_if.sv]
// Channel interfaces for the sort-merge semi-join block.
// Depend on smsj_pkg for the key width.
interface smsj_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic                         list_start;
    logic [smsj_pkg::KEY_W-1:0]   first_column;
    logic [smsj_pkg::KEY_W-1:0]   second_column;

    modport source (output valid, req_type, list_start, first_column, second_column,
                    input ready);
    modport sink   (input valid, req_type, list_start, first_column, second_column,
                    output ready);
endinterface

interface smsj_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, matched, overflow, input ready);
    modport sink   (input valid, matched, overflow, output ready);
endinterface

[rtl/sort_merge_semi_join.sv]
// Top level of the sort-merge semi-join block: controller plus datapath.
// Depends on smsj_pkg, smsj_if, smsj_ctrl, smsj_dp and the defines header.
//
// Channel  | Dir | Beat contents                                   | Handshake
// ---------+-----+-------------------------------------------------+------------
// req      | in  | req_type, list_start, first_column, second_column | valid/ready
// res      | out | matched, overflow                               | valid/ready
// cfg      | in  | cfg_wdata (join_column)                         | cfg_we only
//
// A load beat writes the key to the store at the count. A probe holds the
// request side from its accept cycle until the result register is loaded,
// in these steps: accept, first read, one compare per stored key the pointer
// moves past plus a final compare, result load. If the scan runs off the end
// the last compare is skipped; with nothing left to read, the first read and
// the compares are skipped as well. Over a whole list the pointer moves at
// most LIST_DEPTH times. Reset clears count, pointer, overflow, join column
// and the result valid; the key store is not cleared. A stalled result waits
// in a one-deep output register; loads still flow meanwhile, a probe holds in
// its final state until the register frees.
`include "sort_merge_semi_join_defines.svh"

module sort_merge_semi_join
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    smsj_req_if.sink        req,
    smsj_res_if.source      res
);

    smsj_pkg::cmd_t cmd;
    smsj_pkg::sts_t sts;

    // sequencer: decides read/step/compare per cycle
    smsj_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    // store, pointer, compare and result register
    smsj_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .list_start    (req.list_start),
        .first_column  (req.first_column),
        .second_column (req.second_column),
        .cmd           (cmd),
        .sts           (sts),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .matched       (res.matched),
        .overflow      (res.overflow)
    );

    // a probe beat blocks the request side on the next cycle
    `SMSJ_ASSERT_NEXT(a_probe_busy, req.valid && req.ready && req.req_type, !req.ready)
    // a load beat never stalls the following one
    `SMSJ_ASSERT_NEXT(a_load_single, req.valid && req.ready && !req.req_type, req.ready)
    // a result is only loaded into a free output register
    `SMSJ_ASSERT_NOW(a_emit_free, cmd.emit, !res.valid || res.ready)
    // at most one major command per cycle
    `SMSJ_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.load, cmd.probe, cmd.read, cmd.emit}))

endmodule

[rtl/smsj_ctrl.sv]
// Sequencing state machine of the sort-merge semi-join block.
// Depends on smsj_pkg (state_t, cmd_t, sts_t).
module smsj_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_type,
    input  smsj_pkg::sts_t   sts,
    output logic             req_ready,
    output smsj_pkg::cmd_t   cmd
);

    smsj_pkg::state_t state_reg;
    smsj_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smsj_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == smsj_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            smsj_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type)
                    begin
                        cmd.probe  = 1'b1;
                        state_next = smsj_pkg::ST_LOOK;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            smsj_pkg::ST_LOOK:
            begin
                if (sts.in_range)
                begin
                    cmd.read   = 1'b1;
                    state_next = smsj_pkg::ST_CMP;
                end
                else
                begin
                    cmd.clear_hit = 1'b1;
                    state_next    = smsj_pkg::ST_EMIT;
                end
            end
            smsj_pkg::ST_CMP:
            begin
                if (sts.less)
                begin
                    cmd.step = 1'b1;
                    if (!sts.next_in)
                    begin
                        cmd.clear_hit = 1'b1;
                        state_next    = smsj_pkg::ST_EMIT;
                    end
                end
                else
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = smsj_pkg::ST_EMIT;
                end
            end
            smsj_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = smsj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smsj_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/smsj_dp.sv]
// Datapath of the sort-merge semi-join block: key store, count, pointer,
// overflow flag, key compare and result register. Depends on smsj_pkg.
module smsj_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        list_start,
    input  logic [smsj_pkg::KEY_W-1:0]  first_column,
    input  logic [smsj_pkg::KEY_W-1:0]  second_column,
    input  smsj_pkg::cmd_t              cmd,
    output smsj_pkg::sts_t              sts,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        matched,
    output logic                        overflow
);

    logic [smsj_pkg::KEY_W-1:0]  mem [smsj_pkg::LIST_DEPTH];
    logic [smsj_pkg::KEY_W-1:0]  rdata_reg;
    logic [smsj_pkg::KEY_W-1:0]  key_reg;
    logic [smsj_pkg::CNT_W-1:0]  count_reg;
    logic [smsj_pkg::CNT_W-1:0]  ptr_reg;
    logic [smsj_pkg::CNT_W-1:0]  ptr_inc;
    logic [smsj_pkg::CNT_W-1:0]  count_eff;
    logic                        ovf_reg;
    logic                        join_col_reg;
    logic                        hit_reg;
    logic                        out_valid_reg;
    logic                        matched_reg;
    logic                        overflow_reg;
    logic                        wr_en;
    logic [smsj_pkg::ADDR_W-1:0] rd_addr;
    logic [smsj_pkg::KEY_W-1:0]  row_key;

    assign ptr_inc   = ptr_reg + smsj_pkg::CNT_W'(1);
    assign count_eff = list_start ? '0 : count_reg;
    assign wr_en     = cmd.load && (count_eff != smsj_pkg::CNT_W'(smsj_pkg::LIST_DEPTH));
    assign rd_addr   = cmd.step ? ptr_inc[smsj_pkg::ADDR_W-1:0]
                                : ptr_reg[smsj_pkg::ADDR_W-1:0];
    assign row_key   = (smsj_pkg::ROW_COLUMNS > 1 && join_col_reg) ? second_column
                                                                   : first_column;

    // key store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_eff[smsj_pkg::ADDR_W-1:0]] <= first_column;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read || cmd.step)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe)
        begin
            key_reg <= row_key;
        end
        if (cmd.take_hit)
        begin
            hit_reg <= (rdata_reg == key_reg);
        end
        else if (cmd.clear_hit)
        begin
            hit_reg <= 1'b0;
        end
        if (cmd.emit)
        begin
            matched_reg  <= hit_reg;
            overflow_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            ovf_reg       <= 1'b0;
            join_col_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                join_col_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                if (list_start)
                begin
                    ptr_reg <= '0;
                end
                if (wr_en)
                begin
                    count_reg <= count_eff + smsj_pkg::CNT_W'(1);
                end
                else
                begin
                    count_reg <= count_eff;
                    ovf_reg   <= 1'b1;
                end
            end
            else if (cmd.probe)
            begin
                if (list_start)
                begin
                    ptr_reg <= '0;
                end
                else if (ptr_reg > count_reg)
                begin
                    ptr_reg <= count_reg;
                end
            end
            else if (cmd.step)
            begin
                ptr_reg <= ptr_inc;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.in_range = (ptr_reg < count_reg);
    assign sts.next_in  = (ptr_inc < count_reg);
    assign sts.less     = (rdata_reg < key_reg);
    assign sts.out_free = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

endmodule
